@@ hdl/wcpm_pkg.sv @@
// Shared types and constants for the wildcard class pattern matcher.
`default_nettype none
package wcpm_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  // Pattern syntax bytes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // request accepted, latch it and init the pass
    logic rd_en;   // fetch one pattern position
    logic commit;  // copy next set into the active set
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full_match;
    logic any_alive;
    logic overflow;
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/wcpm_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module wcpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hdl/wcpm_dp.sv @@
// Datapath: pattern store, length, active and next position sets, class scan.
`default_nettype none
module wcpm_dp import wcpm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cmd_t                       cmd_i,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  wire logic [1:0]                 op_i,
  input  wire logic [7:0]                 byte_i,
  output logic      [$clog2(DEPTH+1)-1:0] len_o,
  output sts_t                            sts_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = DEPTH + 1;
  localparam logic [PW-1:0] ONE = PW'(1);

  logic [LW-1:0] len_q, len_d;
  logic [PW-1:0] act_q, nxt_q, nxt_d, bit_k, bit_k1;
  logic          cons_q, cons_d, ovf_q, ovf_d;
  logic          pend_q, pend_d, hit_q, hit_d;
  logic          pvld_q;
  logic [LW-1:0] pidx_q;
  logic [7:0]    sub_q, pc;
  logic          we, act_k, set_k, set_k1;
  op_e           op;

  assign op = op_e'(op_i);

  // Store write on accepted append with room left
  assign we = cmd_i.start && (op == OP_APPEND) && (len_q < LW'(DEPTH));

  wcpm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (pc)
  );

  // Per-position update rules plus star closure
  always_comb begin
    act_k  = act_q[pidx_q];
    bit_k  = ONE << pidx_q;
    bit_k1 = bit_k << 1;
    set_k  = cons_q && act_k && (pc == CH_STAR);
    set_k1 = cons_q && ((act_k && (pc == CH_DOT)) ||
             (act_k && (pc != CH_STAR) && (pc != CH_DOT) && (pc != CH_OPEN) &&
              (pc == sub_q)) ||
             ((pc == CH_CLOSE) && pend_q && hit_q));
    if ((nxt_q[pidx_q] || set_k) && (pc == CH_STAR)) begin
      set_k1 = 1'b1;
    end
  end

  // Next set, class tracking, length and latched request fields
  always_comb begin
    nxt_d  = nxt_q;
    pend_d = pend_q;
    hit_d  = hit_q;
    len_d  = len_q;
    cons_d = cons_q;
    ovf_d  = ovf_q;
    if (cmd_i.start) begin
      pend_d = 1'b0;
      hit_d  = 1'b0;
      ovf_d  = 1'b0;
      cons_d = (op == OP_SUBJECT);
      nxt_d  = (op == OP_SUBJECT) ? '0 : ONE;
      case (op)
        OP_CLEAR: len_d = '0;
        OP_APPEND: begin
          if (len_q < LW'(DEPTH)) begin
            len_d = len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: len_d = len_q;
      endcase
    end else if (pvld_q) begin
      nxt_d = nxt_q | (set_k ? bit_k : '0) | (set_k1 ? bit_k1 : '0);
      // an open class spans to the first close after it
      if (pc == CH_CLOSE) begin
        pend_d = 1'b0;
        hit_d  = 1'b0;
      end else begin
        hit_d  = hit_q | (pend_q && (pc == sub_q) && (pc != CH_COMMA));
        pend_d = pend_q | (act_k && (pc == CH_OPEN));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      act_q  <= ONE;
      nxt_q  <= ONE;
      cons_q <= 1'b0;
      ovf_q  <= 1'b0;
      pend_q <= 1'b0;
      hit_q  <= 1'b0;
      pvld_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      nxt_q  <= nxt_d;
      cons_q <= cons_d;
      ovf_q  <= ovf_d;
      pend_q <= pend_d;
      hit_q  <= hit_d;
      pvld_q <= cmd_i.rd_en;
      if (cmd_i.commit) begin
        act_q <= nxt_q;
      end
    end
  end

  // Index and subject byte need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      pidx_q <= LW'(rd_addr_i);
    end
    if (cmd_i.start) begin
      sub_q <= byte_i;
    end
  end

  assign len_o            = len_q;
  assign sts_o.full_match = act_q[len_q];
  assign sts_o.any_alive  = |act_q;
  assign sts_o.overflow   = ovf_q;

endmodule
`default_nettype wire

@@ hdl/wcpm_ctrl.sv @@
// Controller: request handshake, position scan sequencer, result register.
`default_nettype none
module wcpm_ctrl import wcpm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_valid_i,
  output logic                            s_ready_o,
  output logic                            m_valid_o,
  input  wire logic                       m_ready_i,
  output sts_t                            m_res_o,
  output cmd_t                            cmd_o,
  output logic      [$clog2(DEPTH)-1:0]   rd_addr_o,
  input  wire logic [$clog2(DEPTH+1)-1:0] len_i,
  input  wire sts_t                       sts_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_FLUSH
  } state_e;

  state_e        state_q;
  logic [LW-1:0] idx_q;
  logic          scan_go;

  assign s_ready_o    = (state_q == S_IDLE);
  assign scan_go      = (state_q == S_SCAN) && (idx_q < len_i);
  assign cmd_o.start  = s_valid_i && s_ready_o;
  assign cmd_o.rd_en  = scan_go;
  assign cmd_o.commit = (state_q == S_COMMIT);
  assign rd_addr_o    = idx_q[AW-1:0];

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      m_valid_o <= 1'b0;
      m_res_o   <= '0;
    end else begin
      // result taken downstream; S_FLUSH reloads it on its own
      if (m_valid_o && m_ready_i && (state_q != S_FLUSH)) begin
        m_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (s_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            idx_q <= idx_q + LW'(1);
          end else begin
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: state_q <= S_FLUSH;
        S_FLUSH: begin
          if (!m_valid_o || m_ready_i) begin
            m_valid_o <= 1'b1;
            m_res_o   <= sts_i;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/wildcard_class_pattern_matcher_unit.sv @@
// Top level of the wildcard class pattern matcher.
//
//  channel   dir  payload
//  s_axis    in   tuser = operation, tdata = data_byte
//  m_axis    out  tdata = full_match, any_alive, pattern_overflow
//
// For each request the controller reads every stored pattern position in
// turn through the pattern RAM port, finishes the last read, commits the
// next set and then loads the result register.
// Reset leaves an empty pattern and only position zero active.
// A new request is taken once the previous result sits in the output
// register; a stalled output holds the block after its next pass.
`default_nettype none
module wildcard_class_pattern_matcher_unit import wcpm_pkg::*; #(
  parameter int PATTERN_DEPTH = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  wire logic [1:0] s_axis_tuser,  // [1:0] operation
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata   // [0] full_match [1] any_alive
                                         // [2] pattern_overflow [7:3] zero
);

  localparam int AW = $clog2(PATTERN_DEPTH);
  localparam int LW = $clog2(PATTERN_DEPTH + 1);

  cmd_t          cmd;
  sts_t          sts, res;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] len;

  wcpm_ctrl #(.DEPTH(PATTERN_DEPTH)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .len_i     (len),
    .sts_i     (sts)
  );

  wcpm_dp #(.DEPTH(PATTERN_DEPTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .rd_addr_i (rd_addr),
    .op_i      (s_axis_tuser),
    .byte_i    (s_axis_tdata),
    .len_o     (len),
    .sts_o     (sts)
  );

  assign m_axis_tdata = {5'b0, res.overflow, res.any_alive, res.full_match};

  // One request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted during a pass");

  // A full match means some position is alive
  a_match_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[0] || m_axis_tdata[1]))
    else $error("match without live position");

  // Commit never overlaps a store read or an accepted request
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!cmd.rd_en && !cmd.start))
    else $error("commit overlaps scan");

endmodule
`default_nettype wire

@@ tb/sv/wildcard_class_pattern_matcher_unit_tb.sv @@
// Testbench for the wildcard class pattern matcher: random and directed requests.
`timescale 1ns / 1ps
module wildcard_class_pattern_matcher_unit_tb import wcpm_pkg::*;;

  localparam int DEPTH = 64;

  // Match flags for one request
  typedef struct packed {
    logic full_match;
    logic any_alive;
    logic overflow;
  } match_flags_t;

  // Scoreboard: own copy of the position-set automaton plus expected flags
  class match_scoreboard;
    logic [7:0] pat [DEPTH];
    int unsigned pat_len;
    logic [DEPTH:0] live;
    match_flags_t pending [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      pat_len = 0;
      errors = 0;
      checked = 0;
      for (int i = 0; i < DEPTH; i++) pat[i] = 8'h00;
      restart();
    endfunction

    function void close_stars();
      for (int p = 0; p < pat_len; p++)
        if (live[p] && pat[p] == CH_STAR) live[p+1] = 1'b1;
    endfunction

    function void restart();
      live = '0;
      live[0] = 1'b1;
      close_stars();
    endfunction

    // Advance the active set over one subject byte
    function void step_byte(logic [7:0] c);
      logic [DEPTH:0] nxt;
      int close_at;
      nxt = '0;
      for (int p = 0; p < pat_len; p++) begin
        if (!live[p]) continue;
        if (pat[p] == CH_STAR) begin
          nxt[p] = 1'b1;
        end else if (pat[p] == CH_DOT) begin
          nxt[p+1] = 1'b1;
        end else if (pat[p] == CH_OPEN) begin
          close_at = pat_len;
          for (int k = p + 1; k < pat_len; k++)
            if (pat[k] == CH_CLOSE) begin
              close_at = k;
              break;
            end
          if (close_at < pat_len)
            for (int k = p + 1; k < close_at; k++)
              if (pat[k] != CH_COMMA && pat[k] == c) begin
                nxt[close_at+1] = 1'b1;
                break;
              end
        end else if (pat[p] == c) begin
          nxt[p+1] = 1'b1;
        end
      end
      live = nxt;
      close_stars();
    endfunction

    // Note one accepted request and queue its expected flags
    function void note_request(op_e op, logic [7:0] b);
      match_flags_t f;
      f.overflow = 1'b0;
      case (op)
        OP_CLEAR: begin
          pat_len = 0;
          restart();
        end
        OP_APPEND: begin
          if (pat_len < DEPTH) begin
            pat[pat_len] = b;
            pat_len++;
          end else begin
            f.overflow = 1'b1;
          end
          restart();
        end
        OP_SUBJECT: step_byte(b);
        default: restart();
      endcase
      f.full_match = live[pat_len];
      f.any_alive = |live;
      pending = {pending, f};
    endfunction

    task report(string what, logic got, logic want);
      errors++;
      $display("ERROR %0t: %s got %0b want %0b", $realtime, what, got, want);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic [7:0] d);
      match_flags_t w;
      if (pending.size() == 0) begin
        errors++;
        $display("ERROR %0t: unexpected result %h", $realtime, d);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (d[0] !== w.full_match) report("full_match", d[0], w.full_match);
      if (d[1] !== w.any_alive) report("any_alive", d[1], w.any_alive);
      if (d[2] !== w.overflow) report("pattern_overflow", d[2], w.overflow);
      if (d[7:3] !== 5'd0) report("padding", |d[7:3], 1'b0);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [7:0] m_axis_tdata;

  match_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;
  int unsigned n_sent;
  int unsigned n_overflow;

  wildcard_class_pattern_matcher_unit #(.PATTERN_DEPTH(DEPTH)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

  // Send one request, with random idle cycles before it
  task automatic send(op_e op, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, b);
    n_sent++;
    if (op == OP_APPEND && sb.pending[$].overflow) n_overflow++;
  endtask

  task automatic send_str(op_e op, string s);
    for (int i = 0; i < s.len(); i++) send(op, s[i]);
  endtask

  // Byte from a small alphabet rich in syntax characters
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return CH_STAR;
      1: return CH_DOT;
      2: return CH_OPEN;
      3: return CH_CLOSE;
      4: return CH_COMMA;
      5: return 8'($urandom_range(255));
      default: return 8'h61 + 8'($urandom_range(2));
    endcase
  endfunction

  // One pattern followed by a few subjects
  task automatic random_session(int max_len);
    int plen;
    plen = $urandom_range(max_len);
    send(OP_CLEAR, 8'($urandom_range(255)));
    for (int i = 0; i < plen; i++) send(OP_APPEND, pick_byte());
    for (int s = 0; s < 3; s++) begin
      send(OP_RESTART, 8'($urandom_range(255)));
      for (int i = $urandom_range(plen + 3); i > 0; i--)
        send(OP_SUBJECT, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                   : pick_byte());
    end
    if ($urandom_range(9) == 0)
      send(op_e'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DEPTH + 8) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    n_sent = 0;
    n_overflow = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tuser = OP_CLEAR;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pattern, star, dot, class, unclosed class, end position
    send(OP_SUBJECT, 8'h00);
    send(OP_CLEAR, 8'hFF);
    send_str(OP_APPEND, "a*[b,c].");
    send_str(OP_SUBJECT, "axxcZ");
    send(OP_SUBJECT, 8'hFF);
    send(OP_RESTART, 8'h00);
    send(OP_CLEAR, 8'h00);
    send_str(OP_APPEND, "[ab");
    send(OP_SUBJECT, 8'h61);
    send(OP_CLEAR, 8'h00);
    send(OP_APPEND, 8'hFF);
    send(OP_SUBJECT, 8'hFF);
    send(OP_SUBJECT, 8'hFF);

    // Fill the store and go past it
    send(OP_CLEAR, 8'h00);
    for (int i = 0; i < DEPTH + 2; i++) send(OP_APPEND, (i % 2) ? CH_STAR : 8'h00);
    send(OP_SUBJECT, 8'h00);
    send(OP_SUBJECT, 8'h55);

    // Random phases with different idle mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (ph == 2) hold_cycles = 600;
      while (n_sent < 100 + (ph + 1) * 440)
        random_session(($urandom_range(19) == 0) ? DEPTH + 2 : 12);
    end

    drain();
    $display("Sent %0d requests, checked %0d results, %0d refused appends.",
             n_sent, sb.checked, n_overflow);
    $display("Covered four idle/stall mixes and one long output hold-off.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ wildcard_class_pattern_matcher_unit.f @@
hdl/wcpm_pkg.sv
hdl/wcpm_ram.sv
hdl/wcpm_dp.sv
hdl/wcpm_ctrl.sv
hdl/wildcard_class_pattern_matcher_unit.sv
tb/sv/wildcard_class_pattern_matcher_unit_tb.sv
